FILE: hdl/parallel_flash_command_interface_assert.svh
// assertion macros for the flash interface rtl, included by pfci_ctrl
`ifndef PARALLEL_FLASH_COMMAND_INTERFACE_ASSERT_SVH
`define PARALLEL_FLASH_COMMAND_INTERFACE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PFCI_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PFCI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/pfci_pkg.sv
package pfci_pkg;

    localparam int ADDR_BITS_DEF  = 18;
    localparam int PAGE_BYTES_DEF = 128;

    localparam int ADDR_W     = 18;
    localparam int ADDR_MAX_W = 24;
    localparam int DATA_W     = 8;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int CMD_W      = 15;

    localparam logic [CMD_W-1:0] ADR_A = 15'h5555;
    localparam logic [CMD_W-1:0] ADR_B = 15'h2AAA;

    localparam logic [DATA_W-1:0] BYTE_UNLOCK_A = 8'hAA;
    localparam logic [DATA_W-1:0] BYTE_UNLOCK_B = 8'h55;
    localparam logic [DATA_W-1:0] CMD_RESET     = 8'hF0;
    localparam logic [DATA_W-1:0] CMD_ID        = 8'h90;
    localparam logic [DATA_W-1:0] CMD_ERASE_SET = 8'h80;
    localparam logic [DATA_W-1:0] CMD_SDP_OFF   = 8'h20;
    localparam logic [DATA_W-1:0] CMD_CHIP_ERS  = 8'h10;
    localparam logic [DATA_W-1:0] CMD_PAGE_LOAD = 8'hA0;
    localparam logic [DATA_W-1:0] ERASED_BYTE   = 8'hFF;

    localparam logic [DATA_W-1:0] MAKER_ID_RST = 8'hBF;
    localparam logic [DATA_W-1:0] PART_ID_RST  = 8'h10;

    localparam logic REG_MAKER_ID = 1'b0;
    localparam logic REG_PART_ID  = 1'b1;

    typedef enum logic [1:0] {
        RD_ZERO,
        RD_MAKER,
        RD_PART,
        RD_ARRAY
    } pfci_rdsel_t;

    typedef struct packed {
        logic accept;
        logic load_direct;
        logic load_mem;
    } pfci_ctrl_t;

    typedef struct packed {
        logic        mem_we;
        logic        mem_re;
        pfci_rdsel_t rd_sel;
        logic        busy;
    } pfci_act_t;

endpackage

FILE: hdl/pfci_ctrl.sv
module pfci_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  pfci_pkg::pfci_act_t  act,
    output pfci_pkg::pfci_ctrl_t ctrl
);
    import pfci_pkg::*;

    `include "parallel_flash_command_interface_assert.svh"

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RD   = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    assign s_tready         = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign m_tvalid         = out_valid_reg;
    assign ctrl.accept      = s_tvalid && s_tready;
    assign ctrl.load_direct = ctrl.accept && !act.mem_re;
    assign ctrl.load_mem    = (state_reg == ST_RD);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (ctrl.accept && act.mem_re) begin
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (ctrl.load_direct || ctrl.load_mem) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `PFCI_ASSERT_NOW(a_rd_out_empty, aclk, aresetn, state_reg == ST_RD, !out_valid_reg, "output busy during array read")
    `PFCI_ASSERT_NEXT(a_rd_entered, aclk, aresetn, ctrl.accept && act.mem_re, state_reg == ST_RD, "array read not started")
    `PFCI_ASSERT_NEXT(a_rd_delivers, aclk, aresetn, state_reg == ST_RD, out_valid_reg && state_reg == ST_IDLE, "array read result lost")

endmodule

FILE: hdl/pfci_cmd.sv
module pfci_cmd #(
    parameter int ADDR_BITS  = pfci_pkg::ADDR_BITS_DEF,
    parameter int PAGE_BYTES = pfci_pkg::PAGE_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pfci_pkg::pfci_ctrl_t          ctrl,
    input  logic                          req_type,
    input  logic [pfci_pkg::ADDR_W-1:0]   address,
    input  logic [pfci_pkg::DATA_W-1:0]   write_data,
    output pfci_pkg::pfci_act_t           act,
    output logic [ADDR_BITS-1:0]          mem_addr,
    output logic [pfci_pkg::DATA_W-1:0]   mem_wdata
);
    import pfci_pkg::*;

    localparam logic [2:0] PH_IDLE        = 3'd0;
    localparam logic [2:0] PH_AA1         = 3'd1;
    localparam logic [2:0] PH_CMD1        = 3'd2;
    localparam logic [2:0] PH_ERASE_SETUP = 3'd3;
    localparam logic [2:0] PH_AA2         = 3'd4;
    localparam logic [2:0] PH_CMD2        = 3'd5;
    localparam logic [2:0] PH_PAGE_FIRST  = 3'd6;

    logic [2:0]           phase_reg, phase_next;
    logic                 id_mode_reg, id_mode_next;
    logic                 page_open_reg, page_open_next;
    logic [ADDR_BITS-1:0] page_base_reg, page_base_next;
    logic                 protect_reg, protect_next;
    logic [ADDR_BITS:0]   erase_ptr_reg, erase_ptr_next;

    logic [ADDR_MAX_W-1:0] addr_ext;
    logic [ADDR_BITS-1:0]  addr;
    logic [CMD_W-1:0]      cmd_addr;
    logic [ADDR_BITS-1:0]  page_diff;
    logic [ADDR_BITS:0]    erase_pos;
    logic                  busy;
    logic                  start;
    logic                  unlock_b;
    logic                  in_page;

    assign addr_ext  = ADDR_MAX_W'(address);
    assign addr      = addr_ext[ADDR_BITS-1:0];
    assign cmd_addr  = addr[CMD_W-1:0];
    assign busy      = (erase_ptr_reg != '0);
    assign erase_pos = erase_ptr_reg - 1'b1;
    assign page_diff = addr - page_base_reg;
    assign start     = (cmd_addr == ADR_A) && (write_data == BYTE_UNLOCK_A);
    assign unlock_b  = (cmd_addr == ADR_B) && (write_data == BYTE_UNLOCK_B);
    assign in_page   = page_open_reg && (phase_reg == PH_IDLE) && (addr >= page_base_reg)
                       && (page_diff < ADDR_BITS'(PAGE_BYTES));

    always_comb begin
        phase_next     = phase_reg;
        id_mode_next   = id_mode_reg;
        page_open_next = page_open_reg;
        page_base_next = page_base_reg;
        protect_next   = protect_reg;
        erase_ptr_next = erase_ptr_reg;
        act.mem_we     = 1'b0;
        act.mem_re     = 1'b0;
        act.rd_sel     = RD_ZERO;
        act.busy       = busy;
        mem_addr       = addr;
        mem_wdata      = write_data;

        if (busy) begin
            act.mem_we     = 1'b1;
            mem_addr       = erase_pos[ADDR_BITS-1:0];
            mem_wdata      = ERASED_BYTE;
            erase_ptr_next = erase_ptr_reg[ADDR_BITS] ? '0 : erase_ptr_reg + 1'b1;
        end else if (!req_type) begin
            page_open_next = 1'b0;
            if (id_mode_reg) begin
                act.rd_sel = addr[0] ? RD_PART : RD_MAKER;
            end else begin
                act.rd_sel = RD_ARRAY;
                act.mem_re = 1'b1;
            end
        end else if (in_page) begin
            act.mem_we = 1'b1;
        end else begin
            page_open_next = 1'b0;
            unique case (phase_reg)
                PH_AA1: begin
                    phase_next = start ? PH_AA1 : (unlock_b ? PH_CMD1 : PH_IDLE);
                end
                PH_CMD1: begin
                    phase_next = PH_IDLE;
                    if (cmd_addr == ADR_A) begin
                        unique case (write_data)
                            CMD_RESET: begin
                                id_mode_next = 1'b0;
                            end
                            CMD_ID: begin
                                id_mode_next = 1'b1;
                            end
                            CMD_PAGE_LOAD: begin
                                protect_next = 1'b1;
                                phase_next   = PH_PAGE_FIRST;
                            end
                            CMD_ERASE_SET: begin
                                phase_next = PH_ERASE_SETUP;
                            end
                            default: begin
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
                PH_ERASE_SETUP: begin
                    phase_next = start ? PH_AA2 : PH_IDLE;
                end
                PH_AA2: begin
                    phase_next = unlock_b ? PH_CMD2 : PH_IDLE;
                end
                PH_CMD2: begin
                    phase_next = PH_IDLE;
                    if ((cmd_addr == ADR_A) && (write_data == CMD_CHIP_ERS)) begin
                        erase_ptr_next = (ADDR_BITS + 1)'(1);
                    end else if ((cmd_addr == ADR_A) && (write_data == CMD_SDP_OFF)) begin
                        protect_next = 1'b0;
                    end else if (start) begin
                        phase_next = PH_AA1;
                    end
                end
                PH_PAGE_FIRST: begin
                    page_base_next = addr;
                    page_open_next = 1'b1;
                    act.mem_we     = 1'b1;
                    phase_next     = PH_IDLE;
                end
                default: begin
                    if (start) begin
                        phase_next = PH_AA1;
                    end else begin
                        phase_next = PH_IDLE;
                        act.mem_we = !protect_reg;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            id_mode_reg   <= 1'b0;
            page_open_reg <= 1'b0;
            page_base_reg <= '0;
            protect_reg   <= 1'b1;
            erase_ptr_reg <= '0;
        end else if (ctrl.accept) begin
            phase_reg     <= phase_next;
            id_mode_reg   <= id_mode_next;
            page_open_reg <= page_open_next;
            page_base_reg <= page_base_next;
            protect_reg   <= protect_next;
            erase_ptr_reg <= erase_ptr_next;
        end
    end

endmodule

FILE: hdl/pfci_dp.sv
module pfci_dp #(
    parameter int ADDR_BITS = pfci_pkg::ADDR_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pfci_pkg::pfci_ctrl_t              ctrl,
    input  pfci_pkg::pfci_act_t               act,
    input  logic [ADDR_BITS-1:0]              mem_addr,
    input  logic [pfci_pkg::DATA_W-1:0]       mem_wdata,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [pfci_pkg::DATA_W-1:0]       cfg_wdata,
    output logic [pfci_pkg::APB_DATA_W-1:0]   cfg_rdata,
    output logic [pfci_pkg::DATA_W-1:0]       read_data,
    output logic                              busy_res
);
    import pfci_pkg::*;

    localparam int MemDepth = 1 << ADDR_BITS;

    logic [DATA_W-1:0] mem [0:MemDepth-1];
    logic [DATA_W-1:0] mem_q_reg;
    logic [DATA_W-1:0] maker_id_reg;
    logic [DATA_W-1:0] part_id_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_busy_reg;
    logic [DATA_W-1:0] direct_data;

    always_ff @(posedge aclk) begin
        if (ctrl.accept && act.mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (ctrl.accept && act.mem_re) begin
            mem_q_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            maker_id_reg <= MAKER_ID_RST;
            part_id_reg  <= PART_ID_RST;
        end else if (cfg_we) begin
            if (cfg_index == REG_PART_ID) begin
                part_id_reg <= cfg_wdata;
            end else begin
                maker_id_reg <= cfg_wdata;
            end
        end
    end

    assign cfg_rdata = APB_DATA_W'((cfg_index == REG_PART_ID) ? part_id_reg : maker_id_reg);

    always_comb begin
        unique case (act.rd_sel)
            RD_MAKER: direct_data = maker_id_reg;
            RD_PART:  direct_data = part_id_reg;
            default:  direct_data = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_direct) begin
            out_data_reg <= direct_data;
            out_busy_reg <= act.busy;
        end else if (ctrl.load_mem) begin
            out_data_reg <= mem_q_reg;
            out_busy_reg <= 1'b0;
        end
    end

    assign read_data = out_data_reg;
    assign busy_res  = out_busy_reg;

endmodule

FILE: hdl/parallel_flash_command_interface.sv
// byte-wide flash part with jedec command decode and software data protection
// s_ channel: one bus access per transfer; s_tuser is the access type
//   (0 read, 1 write), s_tdata carries offset and write byte
// m_ channel: one result per access; m_tdata is the read byte, m_tuser the
//   busy flag of a running chip erase
// writes, id-mode reads and accesses during erase are answered without a memory read:
//   the result is in the output register the cycle after the transfer
// array reads pass through the registered read of the cell memory, then the output register
// chip erase clears one byte per accepted access, from offset 0 upward
// a new access is taken while the previous result is being handed over;
//   while m_tready is low and a result waits, or an array read is under way, s_tready stays low
// apb port: maker_id at 0x0, part_id at 0x4; user must keep writes to when the block is idle (unenforced)
// reset (synchronous, aresetn low) clears the command decoder, id mode,
//   page load and erase, turns protection on and restores the id codes;
//   the cell memory is not cleared
module parallel_flash_command_interface #(
    parameter int ADDR_BITS  = pfci_pkg::ADDR_BITS_DEF,
    parameter int PAGE_BYTES = pfci_pkg::PAGE_BYTES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pfci_pkg::S_TDATA_W-1:0]    s_tdata,   // address, write_data, zero pad
    input  logic                              s_tuser,   // req_type
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pfci_pkg::M_TDATA_W-1:0]    m_tdata,   // read_data
    output logic                              m_tuser,   // busy_res
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pfci_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pfci_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pfci_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import pfci_pkg::*;

    pfci_ctrl_t           ctrl;
    pfci_act_t            act;
    logic [ADDR_BITS-1:0] mem_addr;
    logic [DATA_W-1:0]    mem_wdata;
    logic                 cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    pfci_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .act      (act),
        .ctrl     (ctrl)
    );

    pfci_cmd #(
        .ADDR_BITS  (ADDR_BITS),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_cmd (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .req_type   (s_tuser),
        .address    (s_tdata[ADDR_W-1:0]),
        .write_data (s_tdata[ADDR_W+DATA_W-1:ADDR_W]),
        .act        (act),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata)
    );

    pfci_dp #(
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .act       (act),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .cfg_we    (cfg_we),
        .cfg_index (paddr[2]),
        .cfg_wdata (pwdata[DATA_W-1:0]),
        .cfg_rdata (prdata),
        .read_data (m_tdata),
        .busy_res  (m_tuser)
    );

endmodule
